// ===== rtl/core/lbr_pkg.sv =====
// Shared types, constants and constant functions for the log brightness ramp block.
package lbr_pkg;

  // Field widths
  localparam int SAMPLE_W      = 12;
  localparam int DP_W          = 12;
  localparam int LEVEL_W       = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  // Converter resolution and default fixed-point precision
  localparam int ADC_BITS      = 12;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

  // Reset values
  localparam logic [DP_W-1:0]    DARK_POINT_RST = DP_W'(1200);
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST  = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] BRIGHT_RST     = LEVEL_W'(255);
  localparam logic [LEVEL_W-1:0] DARK_RST       = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] LEVEL_RST      = LEVEL_W'(127);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DARK_POINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DARK       = 2'd3;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sensor_sample;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_now;
    logic               level_changed;
    logic               ramp_active;
    logic [LEVEL_W-1:0] goal_now;
    logic               sample_taken;
  } res_t;

  typedef struct packed {
    logic [DP_W-1:0]    adc_dark_point;
    logic [LEVEL_W-1:0] hysteresis_threshold;
    logic [LEVEL_W-1:0] level_bright;
    logic [LEVEL_W-1:0] level_dark;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    MS_IDLE,
    MS_LOG_INIT,
    MS_LOG_STEP,
    MS_LOG_WAIT,
    MS_PROD,
    MS_PROD_WAIT,
    MS_DIV,
    MS_EXP_INIT,
    MS_EXP_STEP,
    MS_EXP_WAIT,
    MS_LEVEL
  } map_state_t;

  // Floor square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] one;
    rem = x;
    res = '0;
    one = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (rem >= res + one) begin
        rem = rem - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // k-th repeated square root of 2 in fixed point with frac fractional bits
  function automatic logic [63:0] exp_root(input int frac, input int k);
    logic [63:0] c;
    c = 64'd2 << frac;
    for (int j = 0; j < k; j++) begin
      c = isqrt64(c << frac);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/log_brightness_ramp_with_hysteresis.sv =====
// Top level: backlight level ramp driven by light samples and ramp ticks.
//
// Each request is a light-sensor sample or a ramp tick and yields exactly one result. A tick
// or a sample that arrives during a ramp has its result ready the cycle after it is taken; a
// sample at zero or at/above the dark point goes through the mapping unit's done register and
// the emit state before its result is loaded. A sample that needs the logarithmic mapping
// runs through one bit-serial multiplier (FRAC_BITS+3 bits, one bit per cycle): two base-2
// logarithms of FRAC_BITS squarings each, one product, a restoring division of FRAC_BITS+3
// steps and up to FRAC_BITS exponent products. The mapping time depends on the ones in the
// fraction of the exponent, and the result is loaded through the emit state after the mapping
// ends. One request is worked on at a time; a new request is taken as soon as the previous
// result has left or is leaving the output register. Configuration writes take effect at once
// and are meant for idle periods; there is no clearing pass after reset.
module log_brightness_ramp_with_hysteresis import lbr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res
);

  top_state_t state, state_next;
  cfg_t       cfg;

  logic [LEVEL_W-1:0] current;
  logic [LEVEL_W-1:0] goal;
  logic [LEVEL_W-1:0] cur_next;
  logic [LEVEL_W-1:0] goal_next;
  logic [LEVEL_W-1:0] diff;
  logic               changed;
  logic               taken;
  logic               out_free;
  logic               accept;
  logic               idle_eq;
  logic               map_start;
  logic               map_done;
  logic [LEVEL_W-1:0] map_level;
  logic               load_res;
  res_t               res_next;

  lbr_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk    (clk),
    .rst    (rst),
    .start  (map_start),
    .sample (req.sensor_sample & ADC_MASK),
    .cfg    (cfg),
    .done   (map_done),
    .level  (map_level)
  );

  assign out_free = !res_valid || !res_stall;
  assign req_stall = (state != ST_IDLE) || !out_free;
  assign accept   = req_valid && !req_stall;
  assign idle_eq  = (current == goal);
  assign diff     = (map_level >= current) ? (map_level - current) : (current - map_level);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (req.req_type == REQ_SAMPLE) && idle_eq) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Level updates, mapping start and result load
  always_comb begin
    map_start = 1'b0;
    load_res  = 1'b0;
    cur_next  = current;
    goal_next = goal;
    changed   = 1'b0;
    taken     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_TICK) begin
            load_res = 1'b1;
            changed  = !idle_eq;
            if (current < goal) begin
              cur_next = current + 1'b1;
            end else if (current > goal) begin
              cur_next = current - 1'b1;
            end
          end else if (idle_eq) begin
            map_start = 1'b1;
          end else begin
            load_res = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_res = 1'b1;
          taken    = 1'b1;
          if (diff >= cfg.hysteresis_threshold) begin
            goal_next = map_level;
          end
        end
      end
      default: begin
        load_res = 1'b0;
      end
    endcase
    res_next = '{level_now:     cur_next,
                 level_changed: changed,
                 ramp_active:   (cur_next != goal_next),
                 goal_now:      goal_next,
                 sample_taken:  taken};
  end

  // Hold state, levels and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      current   <= LEVEL_RST;
      goal      <= LEVEL_RST;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      current <= cur_next;
      goal    <= goal_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= res_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_dark_point       <= DARK_POINT_RST;
      cfg.hysteresis_threshold <= THRESHOLD_RST;
      cfg.level_bright         <= BRIGHT_RST;
      cfg.level_dark           <= DARK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DARK_POINT: cfg.adc_dark_point       <= cfg_data[DP_W-1:0];
        REG_THRESHOLD:  cfg.hysteresis_threshold <= cfg_data[LEVEL_W-1:0];
        REG_BRIGHT:     cfg.level_bright         <= cfg_data[LEVEL_W-1:0];
        REG_DARK:       cfg.level_dark           <= cfg_data[LEVEL_W-1:0];
        default:        cfg.level_dark           <= cfg.level_dark;
      endcase
    end
  end

endmodule

// ===== rtl/core/lbr_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module lbr_mul #(
  parameter int W = 19
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, prod[2*W-1:W]} + (prod[0] ? {1'b0, a_q} : {(W+1){1'b0}});

  // Count the steps and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right, multiplier bits drop out at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      prod <= {{W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[W-1:1]};
    end
  end

endmodule

// ===== rtl/core/lbr_map.sv =====
// Logarithmic sample-to-level mapping unit built around a bit-serial multiplier.
module lbr_map import lbr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output logic                done,
  output logic [LEVEL_W-1:0]  level
);

  localparam int W   = FRAC_BITS + 3;
  localparam int CW  = $clog2(W);
  localparam int FI  = $clog2(FRAC_BITS);
  localparam int LYW = W - FRAC_BITS + 7;

  localparam logic [W-1:0] ONE_Q = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] TWO_Q = W'(2) << FRAC_BITS;

  map_state_t state, state_next;

  logic [SAMPLE_W-1:0]  v;
  logic                 pass_dark;
  logic [W-1:0]         m;
  logic [W-1:0]         r;
  logic [W-1:0]         r_next;
  logic [W-1:0]         lb;
  logic [W-1:0]         ld;
  logic [W-1:0]         y;
  logic [W-1:0]         quo;
  logic [DP_W-1:0]      rem;
  logic [CW-1:0]        cnt;
  logic [2:0]           ipart;
  logic [FRAC_BITS-1:0] frac;

  logic                 mul_start;
  logic                 mul_done;
  logic [W-1:0]         mul_a;
  logic [W-1:0]         mul_b;
  logic [2*W-1:0]       prod;
  logic [W-1:0]         prod_sh;

  logic [W-1:0]         root_tab [FRAC_BITS];
  logic [FI-1:0]        fidx;

  logic                 at_dark;
  logic                 at_zero;
  logic [LEVEL_W-1:0]   x_reg;
  logic [LEVEL_W-1:0]   x_eff;
  logic [2:0]           n;
  logic [W-1:0]         m_init;
  logic                 sq_over;
  logic                 cnt_zero;
  logic                 neg;
  logic [W-1:0]         mag;
  logic [W-1:0]         t_sum;
  logic [DP_W:0]        rem2;
  logic [DP_W:0]        rem_sub;
  logic                 ge;
  logic [LYW-1:0]       ys;
  logic [LYW-1:0]       z;
  logic [LEVEL_W-1:0]   level_sat;

  // Repeated square roots of two, one per fraction bit
  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_root
    assign root_tab[g] = W'(exp_root(FRAC_BITS, FRAC_BITS - g));
  end

  lbr_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign prod_sh  = prod[FRAC_BITS+W-1:FRAC_BITS];
  assign fidx     = cnt[FI-1:0];
  assign cnt_zero = (cnt == '0);

  // Endpoint guard on the incoming sample
  assign at_dark = (sample >= cfg.adc_dark_point);
  assign at_zero = (sample == '0);

  // Normalize the level register for the logarithm
  always_comb begin
    x_reg = pass_dark ? cfg.level_dark : cfg.level_bright;
    x_eff = (x_reg == '0) ? LEVEL_W'(1) : x_reg;
    n     = '0;
    for (int b = 1; b < LEVEL_W; b++) begin
      if (x_eff[b]) begin
        n = 3'(b);
      end
    end
    m_init = W'({x_eff, {FRAC_BITS{1'b0}}} >> n);
  end

  // Squaring step of the logarithm
  always_comb begin
    sq_over = (prod_sh >= TWO_Q);
    r_next  = r;
    if (sq_over) begin
      r_next[cnt] = 1'b1;
    end
  end

  // Log difference, exponent and one restoring division step
  assign neg     = (ld < lb);
  assign mag     = neg ? (lb - ld) : (ld - lb);
  assign t_sum   = neg ? (lb - quo) : (lb + quo);
  assign rem2    = {rem, quo[W-1]};
  assign ge      = (rem2 >= {1'b0, cfg.adc_dark_point});
  assign rem_sub = rem2 - {1'b0, cfg.adc_dark_point};

  // Scale by the integer exponent and saturate
  assign ys        = y[W-1:FRAC_BITS-7];
  assign z         = ys >> (3'd7 - ipart);
  assign level_sat = (|z[LYW-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : z[LEVEL_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      MS_IDLE: begin
        if (start && !(at_dark || at_zero)) begin
          state_next = MS_LOG_INIT;
        end
      end
      MS_LOG_INIT: state_next = MS_LOG_STEP;
      MS_LOG_STEP: state_next = MS_LOG_WAIT;
      MS_LOG_WAIT: begin
        if (mul_done) begin
          if (!cnt_zero) begin
            state_next = MS_LOG_STEP;
          end else if (pass_dark) begin
            state_next = MS_PROD;
          end else begin
            state_next = MS_LOG_INIT;
          end
        end
      end
      MS_PROD: state_next = MS_PROD_WAIT;
      MS_PROD_WAIT: begin
        if (mul_done) begin
          state_next = MS_DIV;
        end
      end
      MS_DIV: begin
        if (cnt_zero) begin
          state_next = MS_EXP_INIT;
        end
      end
      MS_EXP_INIT: state_next = MS_EXP_STEP;
      MS_EXP_STEP: begin
        if (frac[fidx]) begin
          state_next = MS_EXP_WAIT;
        end else if (cnt_zero) begin
          state_next = MS_LEVEL;
        end
      end
      MS_EXP_WAIT: begin
        if (mul_done) begin
          state_next = cnt_zero ? MS_LEVEL : MS_EXP_STEP;
        end
      end
      MS_LEVEL: state_next = MS_IDLE;
      default:  state_next = MS_IDLE;
    endcase
  end

  // Multiplier requests
  always_comb begin
    mul_start = 1'b0;
    mul_a     = m;
    mul_b     = m;
    case (state)
      MS_LOG_STEP: begin
        mul_start = 1'b1;
      end
      MS_PROD: begin
        mul_start = 1'b1;
        mul_a     = mag;
        mul_b     = W'(v);
      end
      MS_EXP_STEP: begin
        mul_start = frac[fidx];
        mul_a     = y;
        mul_b     = root_tab[fidx];
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Hold state and pulse done with the level
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == MS_IDLE) && start && (at_dark || at_zero)) ||
               (state == MS_LEVEL);
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    case (state)
      MS_IDLE: begin
        if (start) begin
          v         <= sample;
          pass_dark <= 1'b0;
          if (at_dark) begin
            level <= cfg.level_dark;
          end else if (at_zero) begin
            level <= cfg.level_bright;
          end
        end
      end
      MS_LOG_INIT: begin
        m   <= m_init;
        r   <= W'(n) << FRAC_BITS;
        cnt <= CW'(FRAC_BITS - 1);
      end
      MS_LOG_WAIT: begin
        if (mul_done) begin
          m   <= sq_over ? (prod_sh >> 1) : prod_sh;
          r   <= r_next;
          cnt <= cnt - 1'b1;
          if (cnt_zero) begin
            if (pass_dark) begin
              ld <= r_next;
            end else begin
              lb        <= r_next;
              pass_dark <= 1'b1;
            end
          end
        end
      end
      MS_PROD_WAIT: begin
        if (mul_done) begin
          rem <= prod[W+DP_W-1:W];
          quo <= prod[W-1:0];
          cnt <= CW'(W - 1);
        end
      end
      MS_DIV: begin
        rem <= ge ? rem_sub[DP_W-1:0] : rem2[DP_W-1:0];
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      MS_EXP_INIT: begin
        ipart <= t_sum[FRAC_BITS+2:FRAC_BITS];
        frac  <= t_sum[FRAC_BITS-1:0];
        y     <= ONE_Q;
        cnt   <= CW'(FRAC_BITS - 1);
      end
      MS_EXP_STEP: begin
        if (!frac[fidx]) begin
          cnt <= cnt - 1'b1;
        end
      end
      MS_EXP_WAIT: begin
        if (mul_done) begin
          y   <= prod_sh;
          cnt <= cnt - 1'b1;
        end
      end
      MS_LEVEL: begin
        level <= level_sat;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// ===== verif/log_brightness_ramp_with_hysteresis_tb.sv =====
// Self-checking testbench for the log brightness ramp block: directed and random requests.
`timescale 1ns / 1ps

module log_brightness_ramp_with_hysteresis_tb;
  import lbr_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 170;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_BURST     = 24;
  // Slowest request: the longest mapping, the widest request gap and the long hold, taken ~7x over
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 1100;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  res_valid;
  logic                  res_stall;
  res_t                  res;

  bit idle_on;
  bit hold_req;
  int n_sent;
  int n_settings;

  // Backlight predictor: register copies, level state and the queue of expected results
  class backlight_scoreboard;
    logic [DP_W-1:0]    dark_point;
    logic [LEVEL_W-1:0] threshold;
    logic [LEVEL_W-1:0] bright;
    logic [LEVEL_W-1:0] dark;
    logic [LEVEL_W-1:0] cur_level;
    logic [LEVEL_W-1:0] goal_level;
    res_t               expected_q[$];
    int                 n_errors;
    int                 n_checked;
    int                 n_evaluated;
    int                 n_moves;

    function new();
      dark_point  = DARK_POINT_RST;
      threshold   = THRESHOLD_RST;
      bright      = BRIGHT_RST;
      dark        = DARK_RST;
      cur_level   = LEVEL_RST;
      goal_level  = LEVEL_RST;
      n_errors    = 0;
      n_checked   = 0;
      n_evaluated = 0;
      n_moves     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DARK_POINT: dark_point = data[DP_W-1:0];
        REG_THRESHOLD:  threshold  = data[LEVEL_W-1:0];
        REG_BRIGHT:     bright     = data[LEVEL_W-1:0];
        REG_DARK:       dark       = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit ramping();
      return cur_level != goal_level;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Floor square root, two bits per step
    function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] acc;
      logic [63:0] root;
      logic [63:0] bit_w;
      acc   = x;
      root  = '0;
      bit_w = 64'd1 << 62;
      while (bit_w > acc) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (acc >= root + bit_w) begin
          acc  = acc - (root + bit_w);
          root = (root >> 1) + bit_w;
        end else begin
          root = root >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return root;
    endfunction

    // Base-2 logarithm of a level by repeated squaring; zero counts as one
    function logic [63:0] frac_log2(logic [LEVEL_W-1:0] x);
      logic [63:0]        m;
      logic [63:0]        r;
      logic [LEVEL_W-1:0] xv;
      int                 n;
      int                 k;
      xv = (x == 0) ? LEVEL_W'(1) : x;
      n  = 0;
      while ((xv >> (n + 1)) != 0) n++;
      m = (64'(xv) << FRAC) >> n;
      r = 64'(n) << FRAC;
      for (k = 1; k <= FRAC; k++) begin
        m = (m * m) >> FRAC;
        if (m >= (64'd2 << FRAC)) begin
          m = m >> 1;
          r[FRAC-k] = 1'b1;
        end
      end
      return r;
    endfunction

    // Two to a fractional power from repeated square roots of two
    function logic [63:0] frac_exp2(logic [63:0] f);
      logic [63:0] y;
      logic [63:0] c;
      int          k;
      y = 64'd1 << FRAC;
      c = 64'd2 << FRAC;
      for (k = 1; k <= FRAC; k++) begin
        c = root_floor(c << FRAC);
        if (f[FRAC-k]) y = (y * c) >> FRAC;
      end
      return y;
    endfunction

    // Map a clamped reading to a level; the endpoints return the registers as written
    function logic [LEVEL_W-1:0] sample_to_level(logic [SAMPLE_W-1:0] v);
      logic signed [63:0] lb;
      logic signed [63:0] ld;
      logic signed [63:0] d;
      logic signed [63:0] t;
      logic [63:0]        mag;
      logic [63:0]        q;
      logic [63:0]        y;
      logic [63:0]        lvl;
      int                 sh;
      if (v >= dark_point) return dark;
      if (v == 0) return bright;
      lb  = frac_log2(bright);
      ld  = frac_log2(dark);
      d   = ld - lb;
      mag = (d < 0) ? -d : d;
      q   = (mag * 64'(v)) / 64'(dark_point);
      t   = (d < 0) ? lb - $signed(q) : lb + $signed(q);
      if (t < 0) t = 0;
      sh  = int'(t[FRAC+3:FRAC]);
      y   = frac_exp2(64'(t[FRAC-1:0]));
      lvl = (y << sh) >> FRAC;
      if (lvl > 64'd255) lvl = 64'd255;
      return lvl[LEVEL_W-1:0];
    endfunction

    // Advance the level state for one accepted request and queue its result
    function void note_req(req_t rq);
      res_t               e;
      logic [SAMPLE_W-1:0] v;
      logic [LEVEL_W-1:0] tgt;
      logic [LEVEL_W-1:0] diff;
      e = '0;
      if (rq.req_type == REQ_SAMPLE) begin
        if (cur_level == goal_level) begin
          v = rq.sensor_sample & ADC_MASK;
          if (v > dark_point) v = dark_point;
          tgt  = sample_to_level(v);
          diff = (tgt > cur_level) ? tgt - cur_level : cur_level - tgt;
          if (diff >= threshold) goal_level = tgt;
          e.sample_taken = 1'b1;
          n_evaluated++;
        end
      end else if (cur_level < goal_level) begin
        cur_level++;
        e.level_changed = 1'b1;
        n_moves++;
      end else if (cur_level > goal_level) begin
        cur_level--;
        e.level_changed = 1'b1;
        n_moves++;
      end
      e.level_now   = cur_level;
      e.ramp_active = (cur_level != goal_level);
      e.goal_now    = goal_level;
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string msg);
      if (n_errors < 40) $display("mismatch: %s", msg);
      n_errors++;
    endtask

    // Compare a result field by field with the oldest expectation
    task check_res(res_t got);
      res_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding", n_checked));
        return;
      end
      e = expected_q.pop_front();
      if (got.level_now !== e.level_now)
        report_mismatch($sformatf("result %0d level_now %0d, predicted %0d",
                                  n_checked, got.level_now, e.level_now));
      if (got.level_changed !== e.level_changed)
        report_mismatch($sformatf("result %0d level_changed %0b, predicted %0b",
                                  n_checked, got.level_changed, e.level_changed));
      if (got.ramp_active !== e.ramp_active)
        report_mismatch($sformatf("result %0d ramp_active %0b, predicted %0b",
                                  n_checked, got.ramp_active, e.ramp_active));
      if (got.goal_now !== e.goal_now)
        report_mismatch($sformatf("result %0d goal_now %0d, predicted %0d",
                                  n_checked, got.goal_now, e.goal_now));
      if (got.sample_taken !== e.sample_taken)
        report_mismatch($sformatf("result %0d sample_taken %0b, predicted %0b",
                                  n_checked, got.sample_taken, e.sample_taken));
    endtask
  endclass

  backlight_scoreboard sb = new();

  log_brightness_ramp_with_hysteresis DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t mk_req(logic kind, logic [SAMPLE_W-1:0] s);
    req_t r;
    r.req_type      = kind;
    r.sensor_sample = s;
    return r;
  endfunction

  // Draw a request: mostly ticks while ramping, mostly samples while idle
  function automatic req_t random_req(bit busy);
    req_t r;
    int   pick;
    int   near;
    if (busy) r.req_type = ($urandom_range(0, 99) < 15) ? REQ_SAMPLE : REQ_TICK;
    else r.req_type = ($urandom_range(0, 99) < 60) ? REQ_SAMPLE : REQ_TICK;
    pick = $urandom_range(0, 19);
    near = int'(sb.dark_point) + int'($urandom_range(0, 6)) - 3;
    if (pick < 2) r.sensor_sample = '0;
    else if (pick < 5) r.sensor_sample = SAMPLE_W'(near);
    else if (pick < 8) r.sensor_sample = SAMPLE_W'($urandom_range(1, 15));
    else r.sensor_sample = SAMPLE_W'($urandom);
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input req_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_req(item);
    n_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Tick until the level reaches the goal
  task automatic settle();
    while (sb.ramping()) send_req(mk_req(REQ_TICK, SAMPLE_W'($urandom)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write all four registers; spare data bits of the threshold and level registers get noise
  task automatic apply_settings(input logic [DP_W-1:0] dp, input logic [LEVEL_W-1:0] thr,
                                input logic [LEVEL_W-1:0] br, input logic [LEVEL_W-1:0] dk);
    write_reg(REG_DARK_POINT, dp);
    write_reg(REG_THRESHOLD, {4'($urandom), thr});
    write_reg(REG_BRIGHT, {4'($urandom), br});
    write_reg(REG_DARK, {4'($urandom), dk});
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Result side: random stall per result, one long hold-off on request
  initial begin
    int hold;
    res_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = idle_on ? $urandom_range(0, 9) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = LONG_HOLD;
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      sb.check_res(res);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("log_brightness_ramp_with_hysteresis_tb: FAIL");
    $finish;
  end

  // Stimulus: reset, directed cases, then random phases under varied settings
  initial begin
    int   ph;
    int   counted;
    bit   busy;
    bit   held_off;
    bit   paused;
    req_t item;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    req_valid  = 1'b0;
    req        = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    n_sent     = 0;
    n_settings = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle tick, bright endpoint, sample ignored during the ramp
    send_req(mk_req(REQ_TICK, '0));
    send_req(mk_req(REQ_SAMPLE, 12'd0));
    send_req(mk_req(REQ_SAMPLE, 12'd700));
    send_req(mk_req(REQ_TICK, 12'hFFF));
    settle();

    // Widest dark point, largest threshold: dark endpoint without a goal change
    drain();
    apply_settings(12'd4095, 8'd255, 8'd255, 8'd1);
    send_req(mk_req(REQ_SAMPLE, 12'd4095));
    send_req(mk_req(REQ_SAMPLE, 12'd1));
    send_req(mk_req(REQ_SAMPLE, 12'd4094));
    settle();

    // Dark point zero, zero levels, zero threshold
    drain();
    apply_settings('0, '0, '0, '0);
    send_req(mk_req(REQ_SAMPLE, 12'd3000));
    send_req(mk_req(REQ_SAMPLE, 12'd5));
    settle();
    send_req(mk_req(REQ_SAMPLE, 12'd0));

    // Bright register zero at the endpoint, then a full ramp up
    drain();
    apply_settings(12'd1, '0, '0, 8'd255);
    send_req(mk_req(REQ_SAMPLE, 12'd0));
    send_req(mk_req(REQ_SAMPLE, 12'd1));
    settle();

    // Logarithm path with dark above bright, then with a zero dark register
    drain();
    apply_settings(12'd100, 8'd1, 8'd1, 8'd255);
    send_req(mk_req(REQ_SAMPLE, 12'd50));
    settle();
    drain();
    apply_settings(12'd100, 8'd1, 8'd200, '0);
    send_req(mk_req(REQ_SAMPLE, 12'd50));
    send_req(mk_req(REQ_SAMPLE, 12'd99));
    settle();

    // Random phases
    held_off = 1'b0;
    paused   = 1'b0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0:       apply_settings(DARK_POINT_RST, THRESHOLD_RST, BRIGHT_RST, DARK_RST);
        4:       apply_settings(12'd4095, 8'd1, 8'd255, 8'd1);
        5:       apply_settings(12'd1, '0, rand_level(), rand_level());
        default: apply_settings(($urandom_range(0, 3) == 0) ? DP_W'($urandom_range(1, 4095))
                                                           : DP_W'($urandom_range(200, 4095)),
                                ($urandom_range(0, 4) == 0) ? rand_level()
                                                           : LEVEL_W'($urandom_range(1, 20)),
                                rand_level(), rand_level());
      endcase
      idle_on = (ph != 1);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // Hold off the result side while requests keep coming
        if (ph == 2 && counted >= 60 && !held_off) begin
          held_off = 1'b1;
          hold_req = 1'b1;
          idle_on  = 1'b0;
          repeat (HOLD_BURST) send_req(mk_req(REQ_TICK, SAMPLE_W'($urandom)));
          idle_on  = 1'b1;
          counted += HOLD_BURST;
        end
        // Pause until every result is back
        if (ph == 3 && counted >= 80 && !paused) begin
          paused = 1'b1;
          drain();
        end
        busy = sb.ramping();
        item = random_req(busy);
        if (!(busy && item.req_type == REQ_SAMPLE)) counted++;
        send_req(item);
      end
    end

    // Wait out the last results and any stray output
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("%0d requests, %0d results checked, %0d register settings",
             n_sent, sb.n_checked, n_settings);
    $display("%0d samples mapped, %0d level steps taken", sb.n_evaluated, sb.n_moves);
    if (sb.n_errors == 0) begin
      $display("log_brightness_ramp_with_hysteresis_tb: PASS");
    end else begin
      $display("log_brightness_ramp_with_hysteresis_tb: FAIL");
    end
    $finish;
  end

endmodule
